// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is low.
`define KHT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// Same-cycle implication built on the macro above.
`define KHT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    `KHT_ASSERT(label, clk, rst_n, (ante) |-> (cons))

`endif

// ===== design/kht_pkg.sv =====
// Package: constants, codes and types of the keyed hold trigger table.
`default_nettype none
package kht_pkg;

    localparam int SLOTS      = 16;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KEY_W      = 16;
    localparam int TGT_W      = 10;
    localparam int CNT_W      = TGT_W + 1;
    localparam int SPK_W      = 8;
    localparam int MSG_W      = 16;
    localparam int STAT_W     = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic REG_HELP_ENABLE = 1'b0;

    typedef enum logic {
        CMD_PUSH  = 1'b0,
        CMD_SWEEP = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_COUNTING = 3'd0,
        ST_FIRED    = 3'd1,
        ST_DEAD     = 3'd2,
        ST_FULL     = 3'd3,
        ST_OFF      = 3'd4,
        ST_SWEPT    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] trigger_key;
        logic [TGT_W-1:0] hold_target;
        logic             one_shot;
        logic [SPK_W-1:0] speaker;
        logic [MSG_W-1:0] message_tag;
    } t_req;

    typedef struct packed {
        logic             fired;
        logic [SPK_W-1:0] fire_speaker;
        logic [MSG_W-1:0] fire_message;
        t_status          status;
    } t_result;

endpackage
`default_nettype wire

// ===== design/kht_if.sv =====
// Valid/ready channel interfaces for push/sweep transactions and results.
`default_nettype none
interface kht_req_if;
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic [kht_pkg::KEY_W-1:0]  trigger_key;
    logic [kht_pkg::TGT_W-1:0]  hold_target;
    logic                       one_shot;
    logic [kht_pkg::SPK_W-1:0]  speaker;
    logic [kht_pkg::MSG_W-1:0]  message_tag;

    modport source (output valid, command, trigger_key, hold_target, one_shot,
                    speaker, message_tag, input ready);
    modport sink   (input valid, command, trigger_key, hold_target, one_shot,
                    speaker, message_tag, output ready);
endinterface

interface kht_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       fired;
    logic [kht_pkg::SPK_W-1:0]  fire_speaker;
    logic [kht_pkg::MSG_W-1:0]  fire_message;
    logic [kht_pkg::STAT_W-1:0] status;

    modport source (output valid, fired, fire_speaker, fire_message, status,
                    input ready);
    modport sink   (input valid, fired, fire_speaker, fire_message, status,
                    output ready);
endinterface
`default_nettype wire

// ===== design/keyed_hold_trigger_table.sv =====
// A sweep or an option-off push goes from accept straight to the emit state; a push
// scans slots one per cycle through one key comparator: a hit on a live key is updated
// and then answered, a disabled key or a full table is answered from the scan, and a new
// key is written into the first free slot after the full scan. A new transaction is taken
// only once the last result is registered, which waits on o_rsp.ready if one is pending.
// Reset (synchronous, active low) empties the table, sets help_enable to 1, drops results.
`default_nettype none
module keyed_hold_trigger_table (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    kht_req_if.sink                             i_req,
    kht_rsp_if.source                           o_rsp,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [kht_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire  [kht_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [kht_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);

    kht_pkg::t_state                r_state, n_state;
    logic [kht_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [kht_pkg::IDX_W-1:0]      r_slot, n_slot;
    logic [kht_pkg::IDX_W-1:0]      r_free, n_free;
    logic                           r_hit, n_hit;
    logic                           r_free_ok, n_free_ok;
    kht_pkg::t_req                  r_in, n_in;
    kht_pkg::t_result               r_res, n_res;
    kht_pkg::t_result               r_out, n_out;
    logic                           r_out_valid, n_out_valid;
    logic [kht_pkg::SLOTS-1:0]      r_used, n_used;
    logic [kht_pkg::SLOTS-1:0]      r_active, n_active;
    logic [kht_pkg::SLOTS-1:0]      r_dead, n_dead;
    logic                           r_help_enable;

    logic [kht_pkg::KEY_W-1:0]      r_key [kht_pkg::SLOTS];
    logic [kht_pkg::CNT_W-1:0]      r_cnt [kht_pkg::SLOTS];

    logic                           wr_en;
    logic                           scan_hit;
    logic                           scan_last;
    logic                           fire;
    logic [kht_pkg::CNT_W-1:0]      cnt_old;
    logic [kht_pkg::CNT_W-1:0]      cnt_new;
    logic [kht_pkg::CNT_W-1:0]      tgt_ext;
    logic                           cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == kht_pkg::REG_HELP_ENABLE);

    always_comb begin
        if (paddr[2] == kht_pkg::REG_HELP_ENABLE) begin
            prdata = {{(kht_pkg::CFG_DATA_W-1){1'b0}}, r_help_enable};
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_help_enable <= 1'b1;
        end else if (cfg_wr) begin
            r_help_enable <= pwdata[0];
        end
    end

    // shared key comparator and count update
    assign scan_hit  = r_used[r_idx] && (r_key[r_idx] == r_in.trigger_key);
    assign scan_last = (r_idx == kht_pkg::IDX_W'(kht_pkg::SLOTS - 1));
    assign tgt_ext   = {1'b0, r_in.hold_target};
    assign cnt_old   = r_hit ? r_cnt[r_slot] : '0;
    assign cnt_new   = (cnt_old <= tgt_ext) ? cnt_old + kht_pkg::CNT_W'(1) : cnt_old;
    assign fire      = (cnt_new == tgt_ext);

    assign i_req.ready = (r_state == kht_pkg::S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_slot      = r_slot;
        n_free      = r_free;
        n_hit       = r_hit;
        n_free_ok   = r_free_ok;
        n_in        = r_in;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_used      = r_used;
        n_active    = r_active;
        n_dead      = r_dead;
        wr_en       = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            kht_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_in.command     = i_req.command;
                    n_in.trigger_key = i_req.trigger_key;
                    n_in.hold_target = i_req.hold_target;
                    n_in.one_shot    = i_req.one_shot;
                    n_in.speaker     = i_req.speaker;
                    n_in.message_tag = i_req.message_tag;
                    n_idx            = '0;
                    n_free_ok        = 1'b0;
                    n_res            = '{fired: 1'b0, fire_speaker: '0,
                                         fire_message: '0,
                                         status: kht_pkg::ST_COUNTING};
                    if (i_req.command == kht_pkg::CMD_SWEEP) begin
                        n_used       = r_used & (r_active | r_dead);
                        n_active     = '0;
                        n_res.status = kht_pkg::ST_SWEPT;
                        n_state      = kht_pkg::S_EMIT;
                    end else if (!r_help_enable) begin
                        n_res.status = kht_pkg::ST_OFF;
                        n_state      = kht_pkg::S_EMIT;
                    end else begin
                        n_state = kht_pkg::S_SCAN;
                    end
                end
            end
            kht_pkg::S_SCAN: begin
                n_idx = r_idx + kht_pkg::IDX_W'(1);
                if (!r_used[r_idx] && !r_free_ok) begin
                    n_free_ok = 1'b1;
                    n_free    = r_idx;
                end
                if (scan_hit) begin
                    if (r_dead[r_idx]) begin
                        n_res.status = kht_pkg::ST_DEAD;
                        n_state      = kht_pkg::S_EMIT;
                    end else begin
                        n_slot  = r_idx;
                        n_hit   = 1'b1;
                        n_state = kht_pkg::S_UPDATE;
                    end
                end else if (scan_last) begin
                    if (r_free_ok) begin
                        n_slot  = r_free;
                        n_hit   = 1'b0;
                        n_state = kht_pkg::S_UPDATE;
                    end else if (!r_used[r_idx]) begin
                        n_slot  = r_idx;
                        n_hit   = 1'b0;
                        n_state = kht_pkg::S_UPDATE;
                    end else begin
                        n_res.status = kht_pkg::ST_FULL;
                        n_state      = kht_pkg::S_EMIT;
                    end
                end
            end
            kht_pkg::S_UPDATE: begin
                wr_en            = 1'b1;
                n_used[r_slot]   = 1'b1;
                n_active[r_slot] = 1'b1;
                if (fire) begin
                    n_dead[r_slot] = r_in.one_shot | (r_hit & r_dead[r_slot]);
                    n_res = '{fired: 1'b1, fire_speaker: r_in.speaker,
                              fire_message: r_in.message_tag,
                              status: kht_pkg::ST_FIRED};
                end else begin
                    n_dead[r_slot] = r_hit & r_dead[r_slot];
                    n_res.status   = kht_pkg::ST_COUNTING;
                end
                n_state = kht_pkg::S_EMIT;
            end
            kht_pkg::S_EMIT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = kht_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kht_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kht_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_used      <= '0;
            r_active    <= '0;
            r_dead      <= '0;
            r_idx       <= '0;
            r_free_ok   <= 1'b0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_used      <= n_used;
            r_active    <= n_active;
            r_dead      <= n_dead;
            r_idx       <= n_idx;
            r_free_ok   <= n_free_ok;
            r_hit       <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_free <= n_free;
        r_in   <= n_in;
        r_res  <= n_res;
        r_out  <= n_out;
        if (wr_en) begin
            r_key[r_slot] <= r_in.trigger_key;
            r_cnt[r_slot] <= cnt_new;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.fired        = r_out.fired;
    assign o_rsp.fire_speaker = r_out.fire_speaker;
    assign o_rsp.fire_message = r_out.fire_message;
    assign o_rsp.status       = r_out.status;

endmodule
`default_nettype wire

// ===== design/kht_checker.sv =====
// Port-level checker for the keyed hold trigger table, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module kht_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             in_valid,
    input wire                             in_ready,
    input wire                             out_valid,
    input wire                             out_ready,
    input wire                             fired,
    input wire [kht_pkg::SPK_W-1:0]        fire_speaker,
    input wire [kht_pkg::MSG_W-1:0]        fire_message,
    input wire [kht_pkg::STAT_W-1:0]       status
);

    `KHT_ASSERT(a_out_hold, i_clk, i_rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(fired) && $stable(fire_speaker) && $stable(fire_message) && $stable(status)))

    `KHT_ASSERT_IMP(a_fired_status, i_clk, i_rst_n, out_valid, fired == (status == kht_pkg::ST_FIRED))

    `KHT_ASSERT_IMP(a_quiet_payload, i_clk, i_rst_n, out_valid && !fired, fire_speaker == '0 && fire_message == '0)

    `KHT_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (in_valid && in_ready) |=> !in_ready)

endmodule

bind keyed_hold_trigger_table kht_checker u_kht_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .in_valid     (i_req.valid),
    .in_ready     (i_req.ready),
    .out_valid    (o_rsp.valid),
    .out_ready    (o_rsp.ready),
    .fired        (o_rsp.fired),
    .fire_speaker (o_rsp.fire_speaker),
    .fire_message (o_rsp.fire_message),
    .status       (o_rsp.status)
);
`default_nettype wire
